/* rtl/bba_pkg.sv */
// Shared types and codes for the block bitmap allocator.
package bba_pkg;

   localparam int BLOCK_W = 12;
   localparam int COUNT_W = 13;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

   localparam logic [1:0] OP_QUERY = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_ALLOC = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_SPACE  = 2'd1;
   localparam logic [1:0] ST_BAD_BLOCK = 2'd2;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [BLOCK_W-1:0] block_number;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [BLOCK_W-1:0] grant_block;
      logic               is_free;
   } rsp_type;

endpackage

/* rtl/block_bitmap_allocator.sv */
// Query/free: an accepted item passes S_ADDR (map read) and S_DATA (result registered).
// Allocate reads map word 0 on accept, then scans one word per cycle in S_SCAN; the
// first-fit scan stops at a free block's word or at the last word, at most MAP_WORDS words.
// Items are handled one at a time: a new item is taken the cycle after the previous result
// is registered; a stalled result holds the next item in its last work state. Synchronous
// reset clears control, then zeroes all map words; items wait, register writes do not.
module block_bitmap_allocator #(
   parameter int MAX_BLOCKS = 4096,
   parameter int WORD_BITS  = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  bba_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output bba_pkg::rsp_type                   rsp_data,
   input  logic                               csr_wr_en,
   input  logic [bba_pkg::COUNT_W-1:0]        csr_wr_data
);

   localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
   localparam int CMP_W     = (CNT_W > bba_pkg::COUNT_W) ? CNT_W : bba_pkg::COUNT_W;
   localparam int BLK_W     = bba_pkg::BLOCK_W;
   // block / WORD_BITS as a multiply by a rounded-up reciprocal, exact for 12-bit blocks
   localparam int DIV_S     = BLK_W + BIT_W;
   localparam int RECIP_W   = BLK_W + 1;
   localparam int PROD_W    = BLK_W + RECIP_W;
   localparam int RECIP     = ((1 << DIV_S) + WORD_BITS - 1) / WORD_BITS;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ADDR,
      S_DATA,
      S_SCAN
   } state_type;

   state_type                    state_ff, state_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   bba_pkg::rsp_type             rsp_data_ff, rsp_data_in;
   logic [bba_pkg::COUNT_W-1:0]  total_ff, total_in;
   logic [ADDR_W-1:0]            clr_addr_ff, clr_addr_in;
   logic [1:0]                   op_ff, op_in;
   logic [BLK_W-1:0]             blk_ff, blk_in;
   logic [BLK_W-1:0]             quot_ff, quot_in;
   logic                         in_range_ff, in_range_in;
   logic [BIT_W-1:0]             bit_ff, bit_in;
   logic [ADDR_W-1:0]            scan_addr_ff, scan_addr_in;
   logic [CMP_W-1:0]             base_ff, base_in;

   logic [WORD_BITS-1:0]         map_mem [MAP_WORDS];
   logic [WORD_BITS-1:0]         rd_data_ff;
   logic                         rd_en;
   logic [ADDR_W-1:0]            rd_addr;
   logic                         wr_en;
   logic [ADDR_W-1:0]            wr_addr;
   logic [WORD_BITS-1:0]         wr_data;

   logic [CMP_W-1:0]             tot_ext;
   logic [CMP_W-1:0]             eff_count;
   logic [PROD_W-1:0]            prod;
   logic [2*BLK_W-1:0]           quot_w;
   logic [BLK_W-1:0]             rem;
   logic [CMP_W-1:0]             limit;
   logic [CMP_W:0]               next_base;
   logic                         last_word;
   logic [WORD_BITS-1:0]         avail;
   logic [WORD_BITS-1:0]         lowest;
   logic [BIT_W-1:0]             hit_idx;
   logic [CMP_W-1:0]             hit_block;
   logic                         hit;
   logic                         deliver;
   logic                         req_take;

   // effective block count: register clamped to the map size
   always_comb begin
      tot_ext   = CMP_W'(total_ff);
      eff_count = (tot_ext > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS) : tot_ext;
   end

   // word index of the requested block
   assign prod = PROD_W'(req_data.block_number) * PROD_W'(RECIP);

   // bit position inside the word
   always_comb begin
      quot_w = (2*BLK_W)'(quot_ff) * (2*BLK_W)'(WORD_BITS);
      rem    = blk_ff - quot_w[BLK_W-1:0];
   end

   // scan step: which bits of the current word are candidates
   always_comb begin
      limit     = eff_count - base_ff;
      next_base = {1'b0, base_ff} + (CMP_W+1)'(WORD_BITS);
      last_word = next_base >= {1'b0, eff_count};
      for (int j = 0; j < WORD_BITS; j++) begin
         avail[j] = rd_data_ff[j] && (CMP_W'(j) < limit) && !(base_ff == '0 && j == 0);
      end
      hit     = |avail;
      lowest  = avail & (~avail + WORD_BITS'(1));
      hit_idx = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         if (lowest[j]) begin
            hit_idx = hit_idx | BIT_W'(j);
         end
      end
      hit_block = base_ff + CMP_W'(hit_idx);
   end

   assign deliver   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      total_in     = csr_wr_en ? csr_wr_data : total_ff;
      clr_addr_in  = clr_addr_ff;
      op_in        = op_ff;
      blk_in       = blk_ff;
      quot_in      = quot_ff;
      in_range_in  = in_range_ff;
      bit_in       = bit_ff;
      scan_addr_in = scan_addr_ff;
      base_in      = base_ff;
      rd_en        = 1'b0;
      rd_addr      = scan_addr_ff;
      wr_en        = 1'b0;
      wr_addr      = scan_addr_ff;
      wr_data      = '0;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_ff;
            if (clr_addr_ff == ADDR_W'(MAP_WORDS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + ADDR_W'(1);
            end
         end
         S_IDLE: begin
            if (req_take) begin
               op_in       = req_data.opcode;
               blk_in      = req_data.block_number;
               quot_in     = BLK_W'(prod >> DIV_S);
               in_range_in = CMP_W'(req_data.block_number) < eff_count;
               if (req_data.opcode == bba_pkg::OP_ALLOC) begin
                  rd_en        = 1'b1;
                  rd_addr      = '0;
                  scan_addr_in = '0;
                  base_in      = '0;
                  state_in     = S_SCAN;
               end else begin
                  state_in = S_ADDR;
               end
            end
         end
         S_ADDR: begin
            bit_in   = rem[BIT_W-1:0];
            rd_en    = in_range_ff;
            rd_addr  = ADDR_W'(quot_ff);
            state_in = S_DATA;
         end
         S_DATA: begin
            if (deliver) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = bba_pkg::ST_OK;
               rsp_data_in.grant_block = '0;
               rsp_data_in.is_free     = 1'b0;
               if (op_ff == bba_pkg::OP_QUERY) begin
                  rsp_data_in.is_free = in_range_ff && rd_data_ff[bit_ff];
               end else if (op_ff == bba_pkg::OP_FREE) begin
                  if (!in_range_ff || blk_ff == '0) begin
                     rsp_data_in.status = bba_pkg::ST_BAD_BLOCK;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = ADDR_W'(quot_ff);
                     wr_data = rd_data_ff | (WORD_BITS'(1) << bit_ff);
                  end
               end
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (hit || last_word) begin
               // hold the word until the result slot frees up
               if (deliver) begin
                  rsp_valid_in        = 1'b1;
                  rsp_data_in.is_free = 1'b0;
                  if (hit) begin
                     rsp_data_in.status      = bba_pkg::ST_OK;
                     rsp_data_in.grant_block = hit_block[BLK_W-1:0];
                     wr_en   = 1'b1;
                     wr_addr = scan_addr_ff;
                     wr_data = rd_data_ff & ~lowest;
                  end else begin
                     rsp_data_in.status      = bba_pkg::ST_NO_SPACE;
                     rsp_data_in.grant_block = '0;
                  end
                  state_in = S_IDLE;
               end
            end else begin
               rd_en        = 1'b1;
               rd_addr      = scan_addr_ff + ADDR_W'(1);
               scan_addr_in = scan_addr_ff + ADDR_W'(1);
               base_in      = next_base[CMP_W-1:0];
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         total_ff     <= bba_pkg::COUNT_RESET;
         clr_addr_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
         clr_addr_ff  <= clr_addr_in;
      end
      rsp_data_ff  <= rsp_data_in;
      op_ff        <= op_in;
      blk_ff       <= blk_in;
      quot_ff      <= quot_in;
      in_range_ff  <= in_range_in;
      bit_ff       <= bit_in;
      scan_addr_ff <= scan_addr_in;
      base_ff      <= base_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= map_mem[rd_addr];
      end
   end

endmodule
